/* sv/mask_centroid_direction_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for mask_centroid_direction
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MASK_CENTROID_DIRECTION_DEFINES_SVH
`define MASK_CENTROID_DIRECTION_DEFINES_SVH

// Same-cycle implication, gated off while reset is asserted.
`define MCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated off while reset is asserted.
`define MCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mcd_pkg.sv */
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and constants of the mask centroid and direction block.
// ----------------------------------------------------------------------------
package mcd_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W     = 8;
	localparam int OUT_W     = 12;
	localparam int DIR_W     = 2;
	localparam int RESULT_W  = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

	// a pixel is set above full scale minus margin
	localparam logic [PIX_W-1:0] SET_LEVEL = PIX_W'(255 - 50);

	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_SAME  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic acc_en;    // pixel request accepted
		logic start;     // frame closed: load the dividers
		logic step;      // one quotient bit
		logic load_out;  // register the result
	} mcd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic frame_end; // current position is the last pixel of the frame
	} mcd_sts_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic [RESULT_W-OUT_W-OUT_W-DIR_W-2:0] pad;
		logic                                  empty_frame;
		logic [DIR_W-1:0]                      direction;
		logic [OUT_W-1:0]                      centroid_col;
		logic [OUT_W-1:0]                      centroid_row;
	} mcd_result_t;

endpackage

/* sv/mcd_ctrl.sv */
// ----------------------------------------------------------------------------
// mcd_ctrl
// Sequencer: pixel intake, division steps and result hand-off.
// ----------------------------------------------------------------------------
module mcd_ctrl #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  mcd_pkg::mcd_sts_t sts,
	output mcd_pkg::mcd_cmd_t cmd
);
	import mcd_pkg::*;

	localparam int POS_W  = $clog2(MAX_DIM);
	localparam int STEP_W = $clog2(POS_W + 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POS_W - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              slot_free;
	logic              accept;

	// the closing pixel of a frame waits until the dividers and the result hand-off are idle
	assign s_axis_tready = (state_q == ST_IDLE) || !sts.frame_end;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.acc_en   = accept;
		cmd.start    = accept && sts.frame_end;
		cmd.step     = 1'b0;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.start) state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_LAST) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) step_q <= '0;
			else if (cmd.step) step_q <= step_q + STEP_W'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* sv/mcd_datapath.sv */
// ----------------------------------------------------------------------------
// mcd_datapath
// Raster position, sums and count, two radix-2 dividers, result register.
// ----------------------------------------------------------------------------
module mcd_datapath #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcd_pkg::mcd_cmd_t           cmd,
	output mcd_pkg::mcd_sts_t           sts,
	input  logic [mcd_pkg::CFG_W-1:0]   frame_width,
	input  logic [mcd_pkg::CFG_W-1:0]   frame_height,
	input  logic [mcd_pkg::PIX_W-1:0]   mask_value,
	output mcd_pkg::mcd_result_t        result
);
	import mcd_pkg::*;

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int CNT_W = 2 * POS_W + 1;
	localparam int SUM_W = 3 * POS_W;
	localparam int DIM_W = (POS_W + 1 > CFG_W) ? POS_W + 1 : CFG_W;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
	localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

	logic [POS_W-1:0] row_pos_q, col_pos_q, prev_col_q;
	logic [SUM_W-1:0] row_sum_q, col_sum_q, row_sum_nx, col_sum_nx;
	logic [CNT_W-1:0] set_count_q, set_count_nx;
	logic [DIM_W-1:0] w_ext, h_ext, eff_w, eff_h;
	logic             pix_set, row_end;

	// divider lanes: 0 row, 1 column
	logic [CNT_W-1:0] div_rem_q [2];
	logic [POS_W-1:0] div_lo_q  [2];
	logic [CNT_W-1:0] div_den_q;
	logic             div_empty_q;
	logic [CNT_W:0]   trial     [2];
	logic             ge        [2];
	logic [CNT_W-1:0] rem_nx    [2];
	logic [POS_W-1:0] lo_nx     [2];

	logic [OUT_W-1:0] out_row_q, out_col_q;
	logic [DIR_W-1:0] out_dir_q;
	logic             out_empty_q;

	// zero acts as one, oversize clamps to the maximum
	always_comb begin
		w_ext = DIM_W'(frame_width);
		h_ext = DIM_W'(frame_height);
		eff_w = (w_ext == '0) ? DIM_ONE : ((w_ext > DIM_MAX) ? DIM_MAX : w_ext);
		eff_h = (h_ext == '0) ? DIM_ONE : ((h_ext > DIM_MAX) ? DIM_MAX : h_ext);
	end

	assign row_end       = DIM_W'(col_pos_q) >= eff_w - DIM_ONE;
	assign sts.frame_end = row_end && (DIM_W'(row_pos_q) >= eff_h - DIM_ONE);

	assign pix_set      = mask_value > SET_LEVEL;
	assign row_sum_nx   = row_sum_q + (pix_set ? SUM_W'(row_pos_q) : '0);
	assign col_sum_nx   = col_sum_q + (pix_set ? SUM_W'(col_pos_q) : '0);
	assign set_count_nx = set_count_q + (pix_set ? CNT_W'(1) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			row_sum_q   <= '0;
			col_sum_q   <= '0;
			set_count_q <= '0;
			prev_col_q  <= '0;
		end else begin
			if (cmd.acc_en) begin
				if (sts.frame_end) begin
					row_pos_q   <= '0;
					col_pos_q   <= '0;
					row_sum_q   <= '0;
					col_sum_q   <= '0;
					set_count_q <= '0;
				end else begin
					row_sum_q   <= row_sum_nx;
					col_sum_q   <= col_sum_nx;
					set_count_q <= set_count_nx;
					if (row_end) begin
						col_pos_q <= '0;
						row_pos_q <= row_pos_q + POS_W'(1);
					end else begin
						col_pos_q <= col_pos_q + POS_W'(1);
					end
				end
			end
			if (cmd.load_out && !div_empty_q) prev_col_q <= div_lo_q[1];
		end
	end

	// The mean is below 2^POS_W, so the top part of the sum is already
	// below the count and only POS_W quotient bits are left to find.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i]  = {div_rem_q[i], div_lo_q[i][POS_W-1]};
			ge[i]     = trial[i] >= {1'b0, div_den_q};
			rem_nx[i] = ge[i] ? CNT_W'(trial[i] - {1'b0, div_den_q}) : CNT_W'(trial[i]);
			lo_nx[i]  = POS_W'({div_lo_q[i], ge[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_rem_q[0] <= CNT_W'(row_sum_nx[SUM_W-1:POS_W]);
			div_rem_q[1] <= CNT_W'(col_sum_nx[SUM_W-1:POS_W]);
			div_lo_q[0]  <= row_sum_nx[POS_W-1:0];
			div_lo_q[1]  <= col_sum_nx[POS_W-1:0];
			div_den_q    <= set_count_nx;
			div_empty_q  <= (set_count_nx == '0);
		end else if (cmd.step) begin
			for (int i = 0; i < 2; i++) begin
				div_rem_q[i] <= rem_nx[i];
				div_lo_q[i]  <= lo_nx[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (div_empty_q) begin
				out_row_q   <= '0;
				out_col_q   <= '0;
				out_dir_q   <= DIR_SAME;
				out_empty_q <= 1'b1;
			end else begin
				out_row_q   <= OUT_W'(div_lo_q[0]);
				out_col_q   <= OUT_W'(div_lo_q[1]);
				out_empty_q <= 1'b0;
				if (div_lo_q[1] < prev_col_q) out_dir_q <= DIR_LEFT;
				else if (div_lo_q[1] > prev_col_q) out_dir_q <= DIR_RIGHT;
				else out_dir_q <= DIR_SAME;
			end
		end
	end

	always_comb begin
		result              = '0;
		result.centroid_row = out_row_q;
		result.centroid_col = out_col_q;
		result.direction    = out_dir_q;
		result.empty_frame  = out_empty_q;
	end

endmodule

/* sv/mask_centroid_direction.sv */
// ----------------------------------------------------------------------------
// mask_centroid_direction
// Centroid of the set pixels of a mask frame, with direction of travel.
// ----------------------------------------------------------------------------
// Mask bytes stream in one per clock, row-major, over a frame of frame_width
// by frame_height pixels (0 acts as 1, values above MAX_DIM clamp to it);
// a byte above 205 marks a set pixel. The pixel that closes a frame hands
// the row and column sums to two radix-2 dividers that find one quotient
// bit per cycle; the result then goes to the output register once that
// register is free. Pixels of the next frame keep streaming meanwhile; only
// the next frame's closing pixel stalls if it arrives while the dividers or
// the hand-off are still busy, and the hand-off waits until the downstream
// side has taken the previous result. Each result gives the truncated mean
// row and column, a direction (left, right or same) against the column of
// the last non-empty frame, and an empty flag; an empty frame reports
// zeros, same, and leaves the kept column alone. Write configuration only
// while idle.
// ----------------------------------------------------------------------------
module mask_centroid_direction #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel requests
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [mcd_pkg::PIX_W-1:0]          s_axis_tdata,   // [7:0] mask_value
	// results
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [11:0] centroid_row, [23:12] centroid_col, [25:24] direction,
	// [26] empty_frame, [31:27] zero
	output logic [mcd_pkg::RESULT_W-1:0]       m_axis_tdata,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcd_pkg::CFG_W-1:0]          cfg_data
);
	import mcd_pkg::*;

	logic [CFG_W-1:0] frame_width_q, frame_height_q;
	mcd_cmd_t         cmd;
	mcd_sts_t         sts;
	mcd_result_t      result;

	// register file: write-only, takes effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
		end
	end

	mcd_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	mcd_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.mask_value   (s_axis_tdata),
		.result       (result)
	);

	// hold the result word until taken
	assign m_axis_tdata = result;

endmodule

/* sv/mcd_checker.sv */
// ----------------------------------------------------------------------------
// mcd_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "mask_centroid_direction_defines.svh"

module mcd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [mcd_pkg::PIX_W-1:0]          s_axis_tdata,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [mcd_pkg::RESULT_W-1:0]       m_axis_tdata,
	input logic                               cfg_we,
	input logic [mcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [mcd_pkg::CFG_W-1:0]          cfg_data
);
	import mcd_pkg::*;

	mcd_result_t res;
	logic        stalled;
	logic        dir_ok;
	logic        empty_ok;

	assign res      = m_axis_tdata;
	assign stalled  = m_axis_tvalid && !m_axis_tready;
	assign dir_ok   = (res.direction == DIR_LEFT) || (res.direction == DIR_RIGHT) ||
		(res.direction == DIR_SAME);
	assign empty_ok = (res.centroid_row == '0) && (res.centroid_col == '0) &&
		(res.direction == DIR_SAME);

	`MCD_ASSERT_NEXT(a_result_held, clk, arst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
	`MCD_ASSERT_NOW(a_dir_code, clk, arst_n, m_axis_tvalid, dir_ok, "direction code out of range")
	`MCD_ASSERT_NOW(a_empty_zero, clk, arst_n, m_axis_tvalid && res.empty_frame, empty_ok, "empty frame without zero centroid and same direction")
	`MCD_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid, res.pad == '0, "result padding not zero")

endmodule

bind mask_centroid_direction mcd_checker u_mcd_checker (.*);
